// ===== rtl/cgbpc_pkg.sv =====
`timescale 1ns / 1ps

package cgbpc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLOR_MODE  = 2'd0;
  localparam logic [1:0] CFG_CORRECT     = 2'd1;
  localparam logic [1:0] CFG_MONO_SELECT = 2'd2;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 2;

  // Item kinds carried in the mode field.
  localparam logic ITEM_PIXEL = 1'b0;
  localparam logic ITEM_WRITE = 1'b1;

  // Fixed RGB565 mono palettes: green, grey, high contrast, amber.
  function automatic logic [15:0] mono_color(input logic [1:0] sel, input logic [1:0] shade);
    logic [15:0] word;
    unique case ({sel, shade})
      4'h0:    word = 16'h9DE1;
      4'h1:    word = 16'h8D61;
      4'h2:    word = 16'h3306;
      4'h3:    word = 16'h09C1;
      4'h4:    word = 16'hFFFF;
      4'h5:    word = 16'hAD55;
      4'h6:    word = 16'h52AA;
      4'h7:    word = 16'h0000;
      4'h8:    word = 16'hFFFF;
      4'h9:    word = 16'hC618;
      4'hA:    word = 16'h4208;
      4'hB:    word = 16'h0000;
      4'hC:    word = 16'hFF36;
      4'hD:    word = 16'hD50B;
      4'hE:    word = 16'h8AC3;
      4'hF:    word = 16'h28A0;
      default: word = 16'h0000;
    endcase
    return word;
  endfunction

  // Pack 5-bit channels into RGB565, widening green by repeating its top bit.
  function automatic logic [15:0] pack565(input logic [4:0] r5, input logic [4:0] g5,
                                          input logic [4:0] b5);
    return {r5, g5, g5[4], b5};
  endfunction

endpackage

// ===== rtl/cgbpc_ram.sv =====
`timescale 1ns / 1ps

module cgbpc_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cgb_pixel_palette_colorizer.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | mode_i, pixel_code_i, entry_slot_i,
//         |           |                          | entry_color_i
// out     | output    | out_valid_o / out_stall_i| panel_word_o
// cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One beat is taken per clock while in_stall_o is low; a pixel passes in turn
// through the palette read, channel sums, and pack and byte swap stages.
// A palette write is done when it is taken and yields no output beat.
// Reset clears the configuration, the stage valids and one valid bit per palette
// entry; an entry never written reads as black, so no clearing pass is needed.
// A stall on the output holds every full stage; empty stages still fill.

module cgb_pixel_palette_colorizer #(
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [5:0]  pixel_code_i,
  input  logic [5:0]  entry_slot_i,
  input  logic [14:0] entry_color_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] panel_word_o,
  // Configuration
  input  logic                                 cfg_we_i,
  input  logic [cgbpc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [cgbpc_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  localparam int unsigned AddrWidth = $clog2(PALETTE_ENTRIES);
  localparam logic [6:0]  NumEntries = 7'(PALETTE_ENTRIES);

  // Configuration registers.
  logic       color_mode_q;
  logic       correct_q;
  logic [1:0] mono_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      correct_q    <= 1'b0;
      mono_sel_q   <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cgbpc_pkg::CFG_COLOR_MODE:  color_mode_q <= cfg_data_i[0];
        cgbpc_pkg::CFG_CORRECT:     correct_q    <= cfg_data_i[0];
        cgbpc_pkg::CFG_MONO_SELECT: mono_sel_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: each stage moves when the one after it has room.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic in_accept;

  assign s3_ready   = !s3_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;

  // Palette write and lookup at the input.
  logic                       slot_ok, code_ok;
  logic                       pal_we, pal_re;
  logic [AddrWidth-1:0]       waddr, raddr;
  logic [14:0]                pal_rdata;
  logic [PALETTE_ENTRIES-1:0] written_q, written_d;

  assign slot_ok = {1'b0, entry_slot_i} < NumEntries;
  assign code_ok = {1'b0, pixel_code_i} < NumEntries;
  assign waddr   = entry_slot_i[AddrWidth-1:0];
  assign raddr   = pixel_code_i[AddrWidth-1:0];
  assign pal_we  = in_accept && (mode_i == cgbpc_pkg::ITEM_WRITE) && slot_ok;
  assign pal_re  = in_accept && (mode_i == cgbpc_pkg::ITEM_PIXEL);

  cgbpc_ram #(
    .WIDTH(15),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(waddr),
    .wdata_i(entry_color_i),
    .re_i   (pal_re),
    .raddr_i(raddr),
    .rdata_o(pal_rdata)
  );

  // Per-entry written flags stand in for clearing the palette at reset.
  always_comb begin
    written_d = written_q;
    if (pal_we) begin
      written_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else begin
      written_q <= written_d;
    end
  end

  // Stage 1: palette read in flight alongside the pixel code.
  logic       s1_hit_q;
  logic [1:0] s1_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= pal_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      s1_hit_q   <= code_ok && written_q[raddr];
      s1_shade_q <= pixel_code_i[1:0];
    end
  end

  // Stage 2: raw or corrected channel values, and the mono word.
  logic [14:0] entry;
  logic [4:0]  r_in, g_in, b_in;
  logic [8:0]  r_sum, b_sum;
  logic [6:0]  g_sum;
  logic [4:0]  r2_d, g2_d, b2_d;
  logic [4:0]  r2_q, g2_q, b2_q;
  logic [15:0] mono2_q;
  logic        color2_q;

  assign entry = s1_hit_q ? pal_rdata : 15'd0;
  assign r_in  = entry[14:10];
  assign g_in  = entry[9:5];
  assign b_in  = entry[4:0];
  assign r_sum = 9'd13 * {4'd0, r_in} + {3'd0, g_in, 1'b0} + {4'd0, b_in};
  assign g_sum = 7'd3 * {2'd0, g_in} + {2'd0, b_in};
  assign b_sum = {3'd0, g_in, 1'b0} + 9'd14 * {4'd0, b_in};

  always_comb begin
    if (correct_q) begin
      r2_d = r_sum[8:4];
      g2_d = g_sum[6:2];
      b2_d = b_sum[8:4];
    end else begin
      r2_d = r_in;
      g2_d = g_in;
      b2_d = b_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      r2_q     <= r2_d;
      g2_q     <= g2_d;
      b2_q     <= b2_d;
      mono2_q  <= cgbpc_pkg::mono_color(mono_sel_q, s1_shade_q);
      color2_q <= color_mode_q;
    end
  end

  // Stage 3: pack to RGB565, pick the path and swap the bytes.
  logic [15:0] rgb565;
  logic [15:0] word3_q;

  assign rgb565 = color2_q ? cgbpc_pkg::pack565(r2_q, g2_q, b2_q) : mono2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      word3_q <= {rgb565[7:0], rgb565[15:8]};
    end
  end

  assign out_valid_o  = s3_valid_q;
  assign panel_word_o = word3_q;

  // A palette write never occupies the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == cgbpc_pkg::ITEM_WRITE)) |=> !s1_valid_q)
    else $error("palette write entered the pixel pipeline");

  // A held stage 1 keeps its palette read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> $stable(pal_rdata))
    else $error("palette read data changed under a held pixel");

  // A write to a slot beyond the palette leaves the written flags alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == cgbpc_pkg::ITEM_WRITE) && !slot_ok) |=> $stable(written_q))
    else $error("out-of-range palette write marked an entry");

  // Stage 1 only fills when the input takes a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(in_valid_i && !in_stall_o))
    else $error("stage 1 filled without an input beat");

endmodule
